>>> hw/rtl/gpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_pkg: shared types and constants
// Command codes, register indexes, the request record that passes through
// the queue, and the configuration bundle.
// ----------------------------------------------------------------------------
package gpd_pkg;

	typedef enum logic [1:0] {
		CMD_PIX  = 2'd0,
		CMD_KER  = 2'd1,
		CMD_CMP  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STEP   = 2'd2;
	localparam logic [1:0] REG_KSIZE  = 2'd3;

	localparam logic [8:0]  RST_WIDTH  = 9'd256;
	localparam logic [8:0]  RST_HEIGHT = 9'd256;
	localparam logic [15:0] RST_STEP   = 16'd256;
	localparam logic [3:0]  RST_KSIZE  = 4'd7;

	localparam int unsigned MIN_KERNEL = 7;
	localparam int unsigned STEP_HALF  = 128;
	localparam int unsigned ROUND_HALF = 32768;

	typedef struct packed {
		logic [8:0]  width;
		logic [8:0]  height;
		logic [15:0] step;
		logic [3:0]  ksize;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] wt;
	} req_t;

	typedef struct packed {
		logic avail;
		req_t req;
	} q_head_t;

endpackage
`default_nettype wire

>>> hw/rtl/gpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_front: request intake
// Takes requests, drops unused codes and out-of-range writes, and holds the
// rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gpd_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_KERNEL = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       command,
	input  wire logic [7:0]       col,
	input  wire logic [7:0]       row,
	input  wire logic [15:0]      red_in,
	input  wire logic [15:0]      green_in,
	input  wire logic [15:0]      blue_in,
	input  wire logic [15:0]      weight,
	input  wire logic             pop,
	output logic                  busy,
	output gpd_pkg::q_head_t      head
);
	import gpd_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	logic       keep;
	req_t       req_c;

	assign busy   = (count_q == 2'd2);
	assign accept = start && !busy;

	// classify: keep in-range writes and computes, drop the rest
	always_comb begin
		keep = 1'b0;
		unique case (cmd_t'(command))
			CMD_PIX: keep = (32'(col) < 32'(MAX_WIDTH)) && (32'(row) < 32'(MAX_HEIGHT));
			CMD_KER: keep = (32'(col) < 32'(MAX_KERNEL)) && (32'(row) < 32'(MAX_KERNEL));
			CMD_CMP: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		req_c.cmd   = cmd_t'(command);
		req_c.col   = col;
		req_c.row   = row;
		req_c.red   = red_in;
		req_c.green = green_in;
		req_c.blue  = blue_in;
		req_c.wt    = weight;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept && keep) begin
			slot_q[wr_ptr_q] <= req_c;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'((accept && keep) ? 1 : 0) - 2'(pop ? 1 : 0);
		end
	end

	assign head.avail = (count_q != 2'd0);
	assign head.req   = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> hw/rtl/gpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_back: execution engine
// Holds the image and kernel memories, performs writes, and runs the
// tap-by-tap filter sequence with a four-stage read/multiply/add pipe.
// ----------------------------------------------------------------------------
module gpd_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_KERNEL = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gpd_pkg::cfg_t    cfg,
	input  wire gpd_pkg::q_head_t head,
	output logic                  pop,
	output logic                  done,
	output logic [15:0]           red_out,
	output logic [15:0]           green_out,
	output logic [15:0]           blue_out,
	output logic                  saturated
);
	import gpd_pkg::*;

	localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(PIX);
	localparam int XAW   = $clog2(MAX_WIDTH);
	localparam int YAW   = $clog2(MAX_HEIGHT);
	localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
	localparam int KAW   = $clog2(TAPS);
	localparam int KW    = $clog2(MAX_KERNEL);
	localparam int KSW   = $clog2(MAX_KERNEL + 1);
	localparam int CW    = ((XAW > YAW) ? XAW : YAW) + 3;
	localparam int ACC_W = 32 + $clog2(TAPS + 1);
	localparam int RND_W = ACC_W + 1 - 16;

	typedef enum logic [2:0] {
		S_IDLE, S_MAP, S_CLAMP, S_RUN, S_DRAIN, S_OUT
	} state_t;

	state_t state_q;

	logic [47:0] img_mem [PIX];
	logic [15:0] ker_mem [TAPS];

	logic [7:0]     col_q, row_q;
	logic [23:0]    prodx_q, prody_q;
	logic [XAW-1:0] wm1_q, sx_q;
	logic [YAW-1:0] hm1_q, sy_q;
	logic [KSW-1:0] k_q;
	logic [KW-1:0]  half_q, kx_q, ky_q;
	logic           v_s1, v_s2, v_s3;
	logic [AW-1:0]  img_addr_s1;
	logic [KAW-1:0] ker_addr_s1;
	logic [47:0]    img_d_s2;
	logic [15:0]    ker_d_s2;
	logic [31:0]    pr_s3, pg_s3, pb_s3;
	logic [ACC_W-1:0] acc_r_q, acc_g_q, acc_b_q;

	logic [31:0]    w_c, h_c, k_c;
	logic [16:0]    sx_c, sy_c;
	logic signed [CW-1:0] px_raw, py_raw;
	logic [XAW-1:0] px_c;
	logic [YAW-1:0] py_c;
	logic           last_col, last_tap;
	logic [RND_W-1:0] rr_c, rg_c, rb_c;
	logic           sr_c, sg_c, sb_c;

	assign pop = (state_q == S_IDLE) && head.avail;

	// clamp sizes in use and force an odd kernel side
	always_comb begin
		w_c = 32'(cfg.width);
		if (w_c < 32'd1) w_c = 32'd1;
		if (w_c > 32'(MAX_WIDTH)) w_c = 32'(MAX_WIDTH);
		h_c = 32'(cfg.height);
		if (h_c < 32'd1) h_c = 32'd1;
		if (h_c > 32'(MAX_HEIGHT)) h_c = 32'(MAX_HEIGHT);
		k_c = 32'(cfg.ksize);
		if (k_c < 32'(MIN_KERNEL)) k_c = 32'(MIN_KERNEL);
		if (k_c > 32'(MAX_KERNEL)) k_c = 32'(MAX_KERNEL);
		if (!k_c[0]) k_c = k_c - 32'd1;
	end

	// map output coordinate onto the source
	assign sx_c = 17'((25'(prodx_q) + 25'(STEP_HALF)) >> 8);
	assign sy_c = 17'((25'(prody_q) + 25'(STEP_HALF)) >> 8);

	// tap coordinates, clamped at the image edges
	always_comb begin
		px_raw = $signed(CW'(sx_q)) + $signed(CW'(kx_q)) - $signed(CW'(half_q));
		py_raw = $signed(CW'(sy_q)) + $signed(CW'(ky_q)) - $signed(CW'(half_q));
		if (px_raw < 0) px_c = '0;
		else if (px_raw > $signed(CW'(wm1_q))) px_c = wm1_q;
		else px_c = px_raw[XAW-1:0];
		if (py_raw < 0) py_c = '0;
		else if (py_raw > $signed(CW'(hm1_q))) py_c = hm1_q;
		else py_c = py_raw[YAW-1:0];
	end

	assign last_col = (kx_q == KW'(k_q - KSW'(1)));
	assign last_tap = last_col && (ky_q == KW'(k_q - KSW'(1)));

	// round and saturate
	always_comb begin
		rr_c = RND_W'((ACC_W'(acc_r_q) + ACC_W'(ROUND_HALF)) >> 16);
		rg_c = RND_W'((ACC_W'(acc_g_q) + ACC_W'(ROUND_HALF)) >> 16);
		rb_c = RND_W'((ACC_W'(acc_b_q) + ACC_W'(ROUND_HALF)) >> 16);
		sr_c = (rr_c > RND_W'(16'hFFFF));
		sg_c = (rg_c > RND_W'(16'hFFFF));
		sb_c = (rb_c > RND_W'(16'hFFFF));
	end

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (pop && head.req.cmd == CMD_PIX) begin
			img_mem[AW'(32'(head.req.row) * MAX_WIDTH + 32'(head.req.col))] <=
				{head.req.red, head.req.green, head.req.blue};
		end
		if (pop && head.req.cmd == CMD_KER) begin
			ker_mem[KAW'(32'(head.req.row) * MAX_KERNEL + 32'(head.req.col))] <= head.req.wt;
		end
		img_d_s2 <= img_mem[img_addr_s1];
		ker_d_s2 <= ker_mem[ker_addr_s1];
	end

	// datapath: mapping, multiplies, accumulation
	always_ff @(posedge clk) begin
		if (pop) begin
			col_q <= head.req.col;
			row_q <= head.req.row;
		end
		if (state_q == S_MAP) begin
			prodx_q <= 24'(col_q) * 24'(cfg.step);
			prody_q <= 24'(row_q) * 24'(cfg.step);
			wm1_q   <= XAW'(w_c - 32'd1);
			hm1_q   <= YAW'(h_c - 32'd1);
			k_q     <= KSW'(k_c);
			half_q  <= KW'(k_c >> 1);
		end
		if (state_q == S_CLAMP) begin
			sx_q <= (sx_c > 17'(wm1_q)) ? wm1_q : XAW'(sx_c);
			sy_q <= (sy_c > 17'(hm1_q)) ? hm1_q : YAW'(sy_c);
		end
		img_addr_s1 <= AW'(32'(py_c) * MAX_WIDTH + 32'(px_c));
		ker_addr_s1 <= KAW'(32'(ky_q) * MAX_KERNEL + 32'(kx_q));
		pr_s3 <= 32'(img_d_s2[47:32]) * 32'(ker_d_s2);
		pg_s3 <= 32'(img_d_s2[31:16]) * 32'(ker_d_s2);
		pb_s3 <= 32'(img_d_s2[15:0]) * 32'(ker_d_s2);
		if (state_q == S_CLAMP) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (v_s3) begin
			acc_r_q <= acc_r_q + ACC_W'(pr_s3);
			acc_g_q <= acc_g_q + ACC_W'(pg_s3);
			acc_b_q <= acc_b_q + ACC_W'(pb_s3);
		end
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kx_q      <= '0;
			ky_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			done      <= 1'b0;
			red_out   <= '0;
			green_out <= '0;
			blue_out  <= '0;
			saturated <= 1'b0;
		end else begin
			done <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (state_q)
				S_IDLE: begin
					if (pop && head.req.cmd == CMD_CMP) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					kx_q    <= '0;
					ky_q    <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					// issue one tap a cycle
					v_s1 <= 1'b1;
					if (last_tap) begin
						state_q <= S_DRAIN;
					end else if (last_col) begin
						kx_q <= '0;
						ky_q <= ky_q + KW'(1);
					end else begin
						kx_q <= kx_q + KW'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					red_out   <= sr_c ? 16'hFFFF : rr_c[15:0];
					green_out <= sg_c ? 16'hFFFF : rg_c[15:0];
					blue_out  <= sb_c ? 16'hFFFF : rb_c[15:0];
					saturated <= sr_c || sg_c || sb_c;
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/gaussian_prefilter_downsampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_prefilter_downsampler: kernel-weighted resampling of an RGB image
// Stores a source image and a square weight kernel, and for each compute
// request filters the source around the mapped point into one output pixel.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------
//  request  | command col row red_in green_in blue_in   | start & !busy
//           | weight                                    |
//  result   | red_out green_out blue_out saturated      | done, one cycle
//  config   | cfg_index cfg_data                        | cfg_we
//
//  The back end performs a pixel or kernel write as it pops it, staying idle.
//  A compute holds the back end through its map, clamp, run, drain and output
//  states, with one image memory read per tap for kernel side k.
//  A two-entry queue takes requests while the back end works; busy is high
//  when it is full. Results cannot be stalled. No clearing pass after reset.
// ----------------------------------------------------------------------------
module gaussian_prefilter_downsampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_KERNEL = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  col,
	input  wire logic [7:0]  row,
	input  wire logic [15:0] red_in,
	input  wire logic [15:0] green_in,
	input  wire logic [15:0] blue_in,
	input  wire logic [15:0] weight,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic [15:0]      red_out,
	output logic [15:0]      green_out,
	output logic [15:0]      blue_out,
	output logic             saturated
);
	import gpd_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.step   <= RST_STEP;
			cfg_q.ksize  <= RST_KSIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data[8:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[8:0];
				REG_STEP:   cfg_q.step   <= cfg_data;
				REG_KSIZE:  cfg_q.ksize  <= cfg_data[3:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	gpd_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_KERNEL(MAX_KERNEL)
	) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.col(col), .row(row), .red_in(red_in), .green_in(green_in),
		.blue_in(blue_in), .weight(weight), .pop(pop), .busy(busy), .head(head)
	);

	gpd_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_KERNEL(MAX_KERNEL)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head(head), .pop(pop),
		.done(done), .red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .saturated(saturated)
	);

endmodule
`default_nettype wire

>>> hw/rtl/gpd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_checker: port-level checks
// Watches result timing and saturation reporting on the top-level ports.
// ----------------------------------------------------------------------------
module gpd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        done,
	input  wire logic [15:0] red_out,
	input  wire logic [15:0] green_out,
	input  wire logic [15:0] blue_out,
	input  wire logic        saturated
);

	// a result is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	// computes are long, so results never come in close succession
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done, 2)) else $error("results too close");

	// a saturated result shows a full-scale channel
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(red_out == 16'hFFFF || green_out == 16'hFFFF || blue_out == 16'hFFFF))
		else $error("saturation without full-scale channel");

endmodule

bind gaussian_prefilter_downsampler gpd_checker u_gpd_checker (
	.clk(clk), .arst_n(arst_n), .done(done), .red_out(red_out),
	.green_out(green_out), .blue_out(blue_out), .saturated(saturated)
);
`default_nettype wire

>>> tb/tb_gaussian_prefilter_downsampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_gaussian_prefilter_downsampler: self-checking bench for the prefilter
// Loads image windows and kernels, then issues compute requests whose taps
// only touch loaded data. Each compute result is predicted when the request
// is built and checked in order against the done strobe. The bench steps
// through several register settings and sender idling phases.
// ----------------------------------------------------------------------------
module tb_gaussian_prefilter_downsampler;
	import gpd_pkg::*;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        sat;
	} pixel_res_t;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] wt;
		bit          has_res;
		pixel_res_t  res;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = 2'd0;
	logic [7:0]  col = 8'd0;
	logic [7:0]  row = 8'd0;
	logic [15:0] red_in = 16'd0;
	logic [15:0] green_in = 16'd0;
	logic [15:0] blue_in = 16'd0;
	logic [15:0] weight = 16'd0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [15:0] cfg_data = 16'd0;
	logic        done;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic        saturated;

	gaussian_prefilter_downsampler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .col(col), .row(row),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in), .weight(weight),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .saturated(saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the image, kernel and registers
	logic [15:0] img_red [65536];
	logic [15:0] img_green [65536];
	logic [15:0] img_blue [65536];
	bit          img_loaded [65536];
	logic [15:0] kern_wt [121];
	bit          kern_loaded [121];
	logic [8:0]  cur_width = RST_WIDTH;
	logic [8:0]  cur_height = RST_HEIGHT;
	logic [15:0] cur_step = RST_STEP;
	logic [3:0]  cur_ksize = RST_KSIZE;

	request_t   pending_q [$];
	pixel_res_t pixel_exp_q [$];
	request_t   cur_req;
	int         idle_pct = 0;
	int         errors = 0;
	int         n_results = 0;
	int         n_sat = 0;
	int         n_sent = 0;

	function automatic int eff_width();
		if (cur_width < 1) return 1;
		if (cur_width > 256) return 256;
		return int'(cur_width);
	endfunction

	function automatic int eff_height();
		if (cur_height < 1) return 1;
		if (cur_height > 256) return 256;
		return int'(cur_height);
	endfunction

	// Filter one output pixel; return 0 if any tap reads unloaded data
	function automatic bit filter_pixel(input logic [7:0] c, input logic [7:0] r,
			output pixel_res_t res);
		int w, h, k, half, sx, sy, py, px, a, t;
		longint unsigned sr, sg, sb, v;
		bit ok;
		w = eff_width();
		h = eff_height();
		k = int'(cur_ksize);
		if (k < MIN_KERNEL) k = MIN_KERNEL;
		if (k > 11) k = 11;
		if (k % 2 == 0) k = k - 1;
		half = k / 2;
		sx = int'((longint'(c) * cur_step + STEP_HALF) >> 8);
		sy = int'((longint'(r) * cur_step + STEP_HALF) >> 8);
		if (sx > w - 1) sx = w - 1;
		if (sy > h - 1) sy = h - 1;
		sr = 0;
		sg = 0;
		sb = 0;
		ok = 1;
		for (int ky = 0; ky < k; ky++) begin
			py = sy + ky - half;
			if (py < 0) py = 0;
			if (py > h - 1) py = h - 1;
			for (int kx = 0; kx < k; kx++) begin
				px = sx + kx - half;
				if (px < 0) px = 0;
				if (px > w - 1) px = w - 1;
				a = py * 256 + px;
				t = ky * 11 + kx;
				if (!img_loaded[a] || !kern_loaded[t]) ok = 0;
				sr += longint'(img_red[a]) * kern_wt[t];
				sg += longint'(img_green[a]) * kern_wt[t];
				sb += longint'(img_blue[a]) * kern_wt[t];
			end
		end
		res.sat = 1'b0;
		v = (sr + ROUND_HALF) >> 16;
		if (v > 65535) begin
			v = 65535;
			res.sat = 1'b1;
		end
		res.red = v[15:0];
		v = (sg + ROUND_HALF) >> 16;
		if (v > 65535) begin
			v = 65535;
			res.sat = 1'b1;
		end
		res.green = v[15:0];
		v = (sb + ROUND_HALF) >> 16;
		if (v > 65535) begin
			v = 65535;
			res.sat = 1'b1;
		end
		res.blue = v[15:0];
		return ok;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] c, input logic [7:0] r,
			input logic [15:0] vr, input logic [15:0] vg, input logic [15:0] vb);
		request_t q;
		int a;
		a = int'(r) * 256 + int'(c);
		q = '{cmd: CMD_PIX, col: c, row: r, red: vr, green: vg, blue: vb,
			wt: 16'($urandom), has_res: 0, res: '{16'd0, 16'd0, 16'd0, 1'b0}};
		img_red[a] = vr;
		img_green[a] = vg;
		img_blue[a] = vb;
		img_loaded[a] = 1;
		pending_q.push_back(q);
	endtask

	task automatic send_weight(input logic [7:0] c, input logic [7:0] r,
			input logic [15:0] w);
		request_t q;
		q = '{cmd: CMD_KER, col: c, row: r, red: 16'($urandom), green: 16'($urandom),
			blue: 16'($urandom), wt: w, has_res: 0, res: '{16'd0, 16'd0, 16'd0, 1'b0}};
		// out-of-range kernel taps are dropped by the block
		if (c < 11 && r < 11) begin
			kern_wt[int'(r) * 11 + int'(c)] = w;
			kern_loaded[int'(r) * 11 + int'(c)] = 1;
		end
		pending_q.push_back(q);
	endtask

	task automatic send_unused(input logic [15:0] v);
		request_t q;
		q = '{cmd: CMD_NONE, col: 8'($urandom), row: 8'($urandom), red: v, green: v,
			blue: v, wt: v, has_res: 0, res: '{16'd0, 16'd0, 16'd0, 1'b0}};
		pending_q.push_back(q);
	endtask

	// Returns 0 if the taps around this output pixel are not all loaded
	function automatic bit send_compute(input logic [7:0] c, input logic [7:0] r);
		request_t q;
		pixel_res_t res;
		if (!filter_pixel(c, r, res)) return 0;
		q = '{cmd: CMD_CMP, col: c, row: r, red: 16'($urandom), green: 16'($urandom),
			blue: 16'($urandom), wt: 16'($urandom), has_res: 1, res: res};
		pending_q.push_back(q);
		return 1;
	endfunction

	function automatic int near_edge(input int lim);
		int t;
		t = $urandom_range(0, 1) ? $urandom_range(0, 9) : lim - 1 - $urandom_range(0, 9);
		return (t < 0) ? 0 : t;
	endfunction

	function automatic logic [7:0] out_coord(input int lim);
		int t;
		if (cur_step == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
		t = (near_edge(lim) * 256) / int'(cur_step) + $urandom_range(0, 2) - 1;
		if (t < 0) t = 0;
		if (t > 255) t = 255;
		return 8'(t);
	endfunction

	// Try up to 40 output pixels near the loaded windows; send a pixel write if none fits
	task automatic gen_compute();
		bit found;
		found = 0;
		for (int tries = 0; tries < 40 && !found; tries++)
			found = send_compute(out_coord(eff_width()), out_coord(eff_height()));
		if (!found)
			send_pixel(8'(near_edge(eff_width())), 8'(near_edge(eff_height())),
				pick_sample(), pick_sample(), pick_sample());
	endtask

	// Load 10 by 10 windows at the four corners of the image in use
	task automatic load_corners();
		int w, h;
		w = eff_width();
		h = eff_height();
		for (int r = 0; r < h; r++)
			if (r < 10 || r >= h - 10)
				for (int c = 0; c < w; c++)
					if ((c < 10 || c >= w - 10) && !img_loaded[r * 256 + c])
						send_pixel(8'(c), 8'(r), pick_sample(), pick_sample(), pick_sample());
	endtask

	task automatic load_kernel(input bit full_scale);
		for (int r = 0; r < 11; r++)
			for (int c = 0; c < 11; c++)
				send_weight(8'(c), 8'(r), full_scale ? 16'hFFFF :
					16'($urandom_range(0, 1500)));
	endtask

	task automatic random_mix(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				gen_compute();
			else if (sel < 80)
				send_pixel(8'(near_edge(eff_width())), 8'(near_edge(eff_height())),
					pick_sample(), pick_sample(), pick_sample());
			else if (sel < 85)
				send_pixel(8'($urandom), 8'($urandom), pick_sample(), pick_sample(),
					pick_sample());
			else if (sel < 95)
				send_weight(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
					$urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500)));
			else
				send_unused(pick_sample());
		end
	endtask

	// Hold until every request is taken and every result seen, then let
	// the back end finish any write still in flight
	task automatic drain();
		while (pending_q.size() != 0 || start || pixel_exp_q.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] s, input logic [15:0] k);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_STEP;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_KSIZE;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_width = w[8:0];
		cur_height = h[8:0];
		cur_step = s;
		cur_ksize = k[3:0];
	endtask

	task automatic run_phase(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] s, input logic [15:0] k, input int idle, input int n);
		drain();
		write_regs(w, h, s, k);
		idle_pct = idle;
		load_corners();
		random_mix(n);
	endtask

	// Request driver: advance on an accepted request, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				n_sent++;
				if (cur_req.has_res) pixel_exp_q.push_back(cur_req.res);
			end
			if (!start || !busy) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_req = pending_q.pop_front();
					start <= 1'b1;
					command <= cur_req.cmd;
					col <= cur_req.col;
					row <= cur_req.row;
					red_in <= cur_req.red;
					green_in <= cur_req.green;
					blue_in <= cur_req.blue;
					weight <= cur_req.wt;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report(input string name, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
		end
	endtask

	// Result monitor: compare each strobe with the oldest expectation
	always @(posedge clk) begin
		pixel_res_t e;
		if (arst_n && done) begin
			if (pixel_exp_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h %h %h %b",
					$time, red_out, green_out, blue_out, saturated);
			end else begin
				e = pixel_exp_q.pop_front();
				n_results++;
				if (e.sat) n_sat++;
				report("red_out", e.red, red_out);
				report("green_out", e.green, green_out);
				report("blue_out", e.blue, blue_out);
				report("saturated", 16'(e.sat), 16'(saturated));
			end
		end
	end

	initial begin
		#(4 * 1500000);
		$display("tb_gaussian_prefilter_downsampler NOT OK");
		$finish;
	end

	initial begin
		bit ok;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: full-scale kernel over the loaded corners to drive saturation
		load_kernel(1);
		load_corners();
		ok = send_compute(8'd0, 8'd0);
		ok = send_compute(8'd255, 8'd255);
		send_pixel(8'd5, 8'd5, 16'hFFFF, 16'h0000, 16'hFFFF);
		ok = send_compute(8'd5, 8'd5);
		// Ignored requests: unused command and kernel taps off the grid
		send_unused(16'hFFFF);
		send_unused(16'h0000);
		send_weight(8'd11, 8'd0, 16'hFFFF);
		send_weight(8'd0, 8'd11, 16'hFFFF);
		send_weight(8'd255, 8'd255, 16'hFFFF);
		load_kernel(0);
		send_weight(8'd0, 8'd0, 16'hFFFF);
		send_weight(8'd10, 8'd10, 16'h0000);
		ok = send_compute(8'd0, 8'd0);
		ok = send_compute(8'd255, 8'd0);
		random_mix(100);

		run_phase(16'd1, 16'd1, 16'd256, 16'd7, 49, 80);
		run_phase(16'd256, 16'd256, 16'd65535, 16'd11, 21, 100);
		run_phase(16'd14, 16'd14, 16'd256, 16'd9, 0, 100);
		run_phase(16'd200, 16'd13, 16'd300, 16'd8, 49, 100);
		run_phase(16'd256, 16'd256, 16'd128, 16'd11, 21, 100);
		// Out-of-range sizes: clamped by the block
		run_phase(16'd0, 16'd511, 16'd256, 16'd15, 0, 70);
		run_phase(16'd511, 16'd0, 16'd1000, 16'd12, 49, 70);
		run_phase(16'd256, 16'd256, 16'd256, 16'd7, 21, 100);
		drain();

		$display("Sent %0d requests over nine register settings; %0d results checked,",
			n_sent, n_results);
		$display("%0d of them saturated, %0d errors.", n_sat, errors);
		if (errors == 0) begin
			$display("tb_gaussian_prefilter_downsampler OK");
		end else begin
			$display("tb_gaussian_prefilter_downsampler NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/gpd_pkg.sv
hw/rtl/gpd_front.sv
hw/rtl/gpd_back.sv
hw/rtl/gaussian_prefilter_downsampler.sv
hw/rtl/gpd_checker.sv
tb/tb_gaussian_prefilter_downsampler.sv
